// ===== hdl/owseq_pkg.sv =====
// ----------------------------------------------------------------------------
// owseq_pkg
// Shared types and constants for the 1-Wire ROM command sequencer: item
// structs, command and action codes, operation states and stage codes.
// ----------------------------------------------------------------------------
package owseq_pkg;

   // number of rom id bytes sent after the match rom command (1 to 8)
   localparam logic [3:0] IdBytes = 4'd8;

   // bits per bus byte
   localparam logic [3:0] ByteBits = 4'd8;

   // rom command bytes
   localparam logic [7:0] MatchRomByte = 8'h55;
   localparam logic [7:0] SkipRomByte  = 8'hCC;

   // command codes carried in the input item
   localparam logic [2:0] CMD_MATCH_ROM  = 3'd0;
   localparam logic [2:0] CMD_SKIP_ROM   = 3'd1;
   localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
   localparam logic [2:0] CMD_READ_BYTE  = 3'd3;
   localparam logic [2:0] CMD_RESET_DONE = 3'd4;
   localparam logic [2:0] CMD_SLOT_DONE  = 3'd5;

   // phases of a match or skip rom sequence
   localparam logic [1:0] STAGE_WAIT_RESET = 2'd0;
   localparam logic [1:0] STAGE_CMD_BYTE   = 2'd1;
   localparam logic [1:0] STAGE_ID_BYTES   = 2'd2;

   // bus actions returned in the result item
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_RESET    = 3'd1,
      ACT_WRITE0   = 3'd2,
      ACT_WRITE1   = 3'd3,
      ACT_READ     = 3'd4,
      ACT_COMPLETE = 3'd5
   } act_type;

   // operation in progress
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_MATCH = 3'd1,
      OP_SKIP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   // input item
   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] rom_id;
      logic [7:0]  write_byte;
      logic        read_bit;
   } req_type;

   // result item
   typedef struct packed {
      act_type    action;
      logic [7:0] read_data;
   } rsp_type;

endpackage

// ===== hdl/owseq_in_stage.sv =====
// ----------------------------------------------------------------------------
// owseq_in_stage
// Input register of the sequencer. Holds one item and stalls the sender only
// while a held item cannot move on to the result register.
// ----------------------------------------------------------------------------
module owseq_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  owseq_pkg::req_type req_data,
   input  logic               advance,
   output logic               item_valid,
   output owseq_pkg::req_type item_data
);

   logic               valid_ff;
   logic               valid_in;
   owseq_pkg::req_type data_ff;
   logic               load;

   // stall only when full and the held item cannot leave
   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;

   // occupancy
   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// ===== hdl/owseq_core.sv =====
// ----------------------------------------------------------------------------
// owseq_core
// Sequencer state and the single-pass update: decodes one item against the
// current operation, computes the bus action and advances the state.
// ----------------------------------------------------------------------------
module owseq_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  owseq_pkg::req_type item,
   output owseq_pkg::rsp_type result
);

   owseq_pkg::op_type op_ff, op_in;
   logic [1:0]        stage_ff, stage_in;
   logic [3:0]        bit_pos_ff, bit_pos_in;
   logic [3:0]        id_pos_ff, id_pos_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        acc_ff, acc_in;
   logic [63:0]       id_ff, id_in;

   logic              is_idle;
   logic              is_rom;
   logic              start_ok;
   logic              reset_ok;
   logic              slot_read;
   logic              slot_send;
   logic              byte_done;
   logic              read_last;
   logic              id_more;
   logic [3:0]        bit_pos_inc;
   logic [3:0]        eff_id_pos;
   logic [7:0]        id_byte;
   logic [7:0]        cmd_byte;
   logic [7:0]        acc_bit;
   logic              send_bit;

   // event decode
   assign is_idle   = (op_ff == owseq_pkg::OP_IDLE);
   assign is_rom    = (op_ff == owseq_pkg::OP_MATCH) || (op_ff == owseq_pkg::OP_SKIP);
   assign start_ok  = is_idle && (item.cmd == owseq_pkg::CMD_MATCH_ROM ||
                      item.cmd == owseq_pkg::CMD_SKIP_ROM ||
                      item.cmd == owseq_pkg::CMD_WRITE_BYTE ||
                      item.cmd == owseq_pkg::CMD_READ_BYTE);
   assign reset_ok  = (item.cmd == owseq_pkg::CMD_RESET_DONE) && is_rom &&
                      (stage_ff == owseq_pkg::STAGE_WAIT_RESET);
   assign slot_read = (item.cmd == owseq_pkg::CMD_SLOT_DONE) &&
                      (op_ff == owseq_pkg::OP_READ);
   assign slot_send = (item.cmd == owseq_pkg::CMD_SLOT_DONE) &&
                      ((op_ff == owseq_pkg::OP_WRITE) ||
                       (is_rom && stage_ff != owseq_pkg::STAGE_WAIT_RESET));

   // bit and byte bookkeeping
   assign bit_pos_inc = bit_pos_ff + 4'd1;
   assign byte_done   = (bit_pos_ff >= owseq_pkg::ByteBits);
   assign read_last   = (bit_pos_inc >= owseq_pkg::ByteBits);
   assign send_bit    = shift_ff[bit_pos_ff[2:0]];
   assign acc_bit     = acc_ff | ({7'd0, item.read_bit} << bit_pos_ff[2:0]);

   // id byte selection; the first id byte follows the command byte
   assign eff_id_pos = (stage_ff == owseq_pkg::STAGE_CMD_BYTE) ? 4'd0 : id_pos_ff;
   assign id_more    = (eff_id_pos < owseq_pkg::IdBytes) && (eff_id_pos < 4'd8);
   assign id_byte    = id_ff[{eff_id_pos[2:0], 3'b000} +: 8];
   assign cmd_byte   = (op_ff == owseq_pkg::OP_MATCH) ? owseq_pkg::MatchRomByte
                                                      : owseq_pkg::SkipRomByte;

   // next state
   always_comb begin
      op_in      = op_ff;
      stage_in   = stage_ff;
      bit_pos_in = bit_pos_ff;
      id_pos_in  = id_pos_ff;
      shift_in   = shift_ff;
      acc_in     = acc_ff;
      id_in      = id_ff;
      if (step) begin
         priority if (start_ok) begin
            unique case (item.cmd)
               owseq_pkg::CMD_MATCH_ROM: begin
                  op_in    = owseq_pkg::OP_MATCH;
                  stage_in = owseq_pkg::STAGE_WAIT_RESET;
                  id_in    = item.rom_id;
               end
               owseq_pkg::CMD_SKIP_ROM: begin
                  op_in    = owseq_pkg::OP_SKIP;
                  stage_in = owseq_pkg::STAGE_WAIT_RESET;
               end
               owseq_pkg::CMD_WRITE_BYTE: begin
                  op_in      = owseq_pkg::OP_WRITE;
                  shift_in   = item.write_byte;
                  bit_pos_in = 4'd1;
               end
               owseq_pkg::CMD_READ_BYTE: begin
                  op_in      = owseq_pkg::OP_READ;
                  acc_in     = 8'd0;
                  bit_pos_in = 4'd0;
               end
               default: begin
               end
            endcase
         end else if (reset_ok) begin
            stage_in   = owseq_pkg::STAGE_CMD_BYTE;
            shift_in   = cmd_byte;
            bit_pos_in = 4'd1;
         end else if (slot_read) begin
            acc_in     = acc_bit;
            bit_pos_in = bit_pos_inc;
            if (read_last) begin
               op_in = owseq_pkg::OP_IDLE;
            end
         end else if (slot_send) begin
            priority if (!byte_done) begin
               bit_pos_in = bit_pos_inc;
            end else if (op_ff == owseq_pkg::OP_MATCH && id_more) begin
               stage_in   = owseq_pkg::STAGE_ID_BYTES;
               id_pos_in  = eff_id_pos + 4'd1;
               shift_in   = id_byte;
               bit_pos_in = 4'd1;
            end else begin
               op_in    = owseq_pkg::OP_IDLE;
               stage_in = owseq_pkg::STAGE_WAIT_RESET;
            end
         end else begin
         end
      end
   end

   // result item
   always_comb begin
      result.action    = owseq_pkg::ACT_NONE;
      result.read_data = 8'd0;
      priority if (start_ok) begin
         unique case (item.cmd)
            owseq_pkg::CMD_MATCH_ROM,
            owseq_pkg::CMD_SKIP_ROM:   result.action = owseq_pkg::ACT_RESET;
            owseq_pkg::CMD_WRITE_BYTE: result.action = item.write_byte[0] ?
                                          owseq_pkg::ACT_WRITE1 : owseq_pkg::ACT_WRITE0;
            owseq_pkg::CMD_READ_BYTE:  result.action = owseq_pkg::ACT_READ;
            default:                   result.action = owseq_pkg::ACT_NONE;
         endcase
      end else if (reset_ok) begin
         result.action = cmd_byte[0] ? owseq_pkg::ACT_WRITE1 : owseq_pkg::ACT_WRITE0;
      end else if (slot_read) begin
         if (read_last) begin
            result.action    = owseq_pkg::ACT_COMPLETE;
            result.read_data = acc_bit;
         end else begin
            result.action = owseq_pkg::ACT_READ;
         end
      end else if (slot_send) begin
         priority if (!byte_done) begin
            result.action = send_bit ? owseq_pkg::ACT_WRITE1 : owseq_pkg::ACT_WRITE0;
         end else if (op_ff == owseq_pkg::OP_MATCH && id_more) begin
            result.action = id_byte[0] ? owseq_pkg::ACT_WRITE1 : owseq_pkg::ACT_WRITE0;
         end else begin
            result.action = owseq_pkg::ACT_COMPLETE;
         end
      end else begin
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= owseq_pkg::OP_IDLE;
         stage_ff   <= owseq_pkg::STAGE_WAIT_RESET;
         bit_pos_ff <= 4'd0;
         id_pos_ff  <= 4'd0;
         shift_ff   <= 8'd0;
         acc_ff     <= 8'd0;
      end else begin
         op_ff      <= op_in;
         stage_ff   <= stage_in;
         bit_pos_ff <= bit_pos_in;
         id_pos_ff  <= id_pos_in;
         shift_ff   <= shift_in;
         acc_ff     <= acc_in;
      end
   end

   // latched rom id, written at every match start
   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

`ifndef SYNTHESIS
   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff <= owseq_pkg::ByteBits)
      else $error("bit position beyond one byte");

   a_id_pos_range: assert property (@(posedge clock) disable iff (reset)
      id_pos_ff <= owseq_pkg::IdBytes)
      else $error("id byte position beyond id length");

   a_id_stage_match: assert property (@(posedge clock) disable iff (reset)
      stage_ff == owseq_pkg::STAGE_ID_BYTES |-> op_ff == owseq_pkg::OP_MATCH)
      else $error("id stage outside match rom");

   a_complete_idle: assert property (@(posedge clock) disable iff (reset)
      step && result.action == owseq_pkg::ACT_COMPLETE |=> op_ff == owseq_pkg::OP_IDLE)
      else $error("not idle after completion");
`endif

endmodule

// ===== hdl/owseq_out_stage.sv =====
// ----------------------------------------------------------------------------
// owseq_out_stage
// Result register. Takes a new result whenever it is empty or its current
// result is being taken, so the input side keeps moving.
// ----------------------------------------------------------------------------
module owseq_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  owseq_pkg::rsp_type result,
   output logic               ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output owseq_pkg::rsp_type rsp_data
);

   logic               valid_ff;
   logic               valid_in;
   owseq_pkg::rsp_type data_ff;

   // free when empty or when the held result leaves this cycle
   assign ready = ~valid_ff | ~rsp_stall;

   // occupancy
   always_comb begin
      priority if (step) begin
         valid_in = 1'b1;
      end else if (ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hdl/onewire_rom_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// onewire_rom_command_sequencer
// Byte and ROM command layer of a 1-Wire bus master.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item per command or bus event (start match rom, start
//   skip rom, write byte, read byte, reset done, slot done with the sampled
//   bit). rsp_ channel: exactly one item per request, giving the next bus
//   action (none, reset pulse, write-0, write-1, read slot, complete) and the
//   assembled byte when a read completes.
//   Throughput: one item per cycle while rsp_stall is low; the input
//   register feeds one short decode and update pass straight into the
//   result register.
//   The result register frees itself whenever its item is taken, so a held
//   result does not block a new request while rsp_stall is low.
//   When the receiver raises rsp_stall, the result holds, the input register
//   holds one more item, and req_stall rises once both are full.
//   Reset (synchronous) empties both registers and returns the sequencer to
//   idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module onewire_rom_command_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  owseq_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output owseq_pkg::rsp_type rsp_data
);

   logic               item_valid;
   owseq_pkg::req_type item_data;
   logic               ready;
   logic               step;
   owseq_pkg::rsp_type result;

   // an item moves to the result register when that register is free
   assign step = item_valid & ready;

   owseq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (ready),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   owseq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_data),
      .result (result)
   );

   owseq_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb_onewire_rom_command_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_onewire_rom_command_sequencer
// Self-checking bench for the 1-Wire ROM command sequencer. A scoreboard
// tracks the sequencer state, predicts the bus action for every accepted
// item and checks each returned item in order. The run covers directed
// corner cases, then random match rom, skip rom, write and read sequences
// with stray commands mixed in, under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_onewire_rom_command_sequencer;
   import owseq_pkg::*;

   // command codes the sequencer does not decode
   localparam logic [2:0] CMD_RSVD_6 = 3'd6;
   localparam logic [2:0] CMD_RSVD_7 = 3'd7;

   // sampled bit patterns for read sequences
   localparam int BITS_RANDOM = 0;
   localparam int BITS_LOW    = 1;
   localparam int BITS_HIGH   = 2;

   // cumulative item counts at the end of each idling phase
   localparam int PHASE1_ITEMS = 320;
   localparam int PHASE2_ITEMS = 640;
   localparam int PHASE3_ITEMS = 950;

   // tracks sequencer state and holds the bus actions still to come back
   class bus_action_scoreboard;
      op_type      op        = OP_IDLE;
      logic [1:0]  stage     = STAGE_WAIT_RESET;
      logic [3:0]  bit_pos   = '0;
      logic [3:0]  id_pos    = '0;
      logic [7:0]  shift_reg = '0;
      logic [7:0]  read_acc  = '0;
      logic [63:0] id_latch  = '0;
      rsp_type     pending_actions[$];
      int          failures  = 0;

      // latch a byte to send and return the slot for its lsb
      function act_type load_byte(logic [7:0] value);
         shift_reg = value;
         bit_pos   = 4'd1;
         return value[0] ? ACT_WRITE1 : ACT_WRITE0;
      endfunction

      function act_type next_write_slot();
         act_type slot;
         slot = shift_reg[bit_pos[2:0]] ? ACT_WRITE1 : ACT_WRITE0;
         bit_pos++;
         return slot;
      endfunction

      // start the next rom id byte, or finish the match sequence
      function act_type next_id_byte();
         logic [2:0] sel;
         if (id_pos < IdBytes) begin
            sel = id_pos[2:0];
            id_pos++;
            return load_byte(id_latch[{sel, 3'b000} +: 8]);
         end
         op    = OP_IDLE;
         stage = STAGE_WAIT_RESET;
         return ACT_COMPLETE;
      endfunction

      function rsp_type predict_bus_action(req_type r);
         rsp_type res;
         res.action    = ACT_NONE;
         res.read_data = '0;
         case (r.cmd)
            CMD_MATCH_ROM, CMD_SKIP_ROM: begin
               if (op == OP_IDLE) begin
                  op = (r.cmd == CMD_MATCH_ROM) ? OP_MATCH : OP_SKIP;
                  if (r.cmd == CMD_MATCH_ROM) id_latch = r.rom_id;
                  stage      = STAGE_WAIT_RESET;
                  res.action = ACT_RESET;
               end
            end
            CMD_WRITE_BYTE: begin
               if (op == OP_IDLE) begin
                  op         = OP_WRITE;
                  res.action = load_byte(r.write_byte);
               end
            end
            CMD_READ_BYTE: begin
               if (op == OP_IDLE) begin
                  op         = OP_READ;
                  read_acc   = '0;
                  bit_pos    = '0;
                  res.action = ACT_READ;
               end
            end
            CMD_RESET_DONE: begin
               if ((op == OP_MATCH || op == OP_SKIP) && stage == STAGE_WAIT_RESET) begin
                  stage      = STAGE_CMD_BYTE;
                  res.action = load_byte(op == OP_MATCH ? MatchRomByte : SkipRomByte);
               end
            end
            CMD_SLOT_DONE: begin
               // read slots assemble the byte lsb first
               if (op == OP_READ) begin
                  if (r.read_bit) read_acc[bit_pos[2:0]] = 1'b1;
                  bit_pos++;
                  if (bit_pos < ByteBits) begin
                     res.action = ACT_READ;
                  end else begin
                     res.action    = ACT_COMPLETE;
                     res.read_data = read_acc;
                     op            = OP_IDLE;
                  end
               end else if (op == OP_WRITE ||
                            ((op == OP_MATCH || op == OP_SKIP) &&
                             stage != STAGE_WAIT_RESET)) begin
                  if (bit_pos < ByteBits) begin
                     res.action = next_write_slot();
                  end else if (op == OP_MATCH) begin
                     if (stage == STAGE_CMD_BYTE) begin
                        stage  = STAGE_ID_BYTES;
                        id_pos = '0;
                     end
                     res.action = next_id_byte();
                  end else begin
                     op         = OP_IDLE;
                     stage      = STAGE_WAIT_RESET;
                     res.action = ACT_COMPLETE;
                  end
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_command(req_type r);
         pending_actions.push_back(predict_bus_action(r));
      endfunction

      function void check_action(rsp_type got);
         rsp_type want;
         if (pending_actions.size() == 0) begin
            $error("unexpected result item: action %0d read_data %0h",
                   got.action, got.read_data);
            failures++;
            return;
         end
         want = pending_actions.pop_front();
         if (got.action !== want.action) begin
            $error("action mismatch: expected %0d, actual %0d", want.action, got.action);
            failures++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0h, actual %0h",
                   want.read_data, got.read_data);
            failures++;
         end
      endfunction

      function int pending();
         return pending_actions.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int useful_items  = 0;

   bus_action_scoreboard scoreboard = new;

   onewire_rom_command_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // watch both handshakes
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) scoreboard.note_command(req_data);
      if (!reset && rsp_valid && !rsp_stall) scoreboard.check_action(rsp_data);
   end

   // run timeout
   initial begin
      #2_000_000;
      $display("tb_onewire_rom_command_sequencer: FAIL");
      $finish;
   end

   // random payload around a given command
   function automatic req_type random_request(input logic [2:0] cmd);
      req_type r;
      r.cmd        = cmd;
      r.rom_id     = {$urandom, $urandom};
      r.write_byte = 8'($urandom_range(255));
      r.read_bit   = 1'($urandom_range(1));
      return r;
   endfunction

   // present one item, with random idle cycles ahead of it
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_cmd(input logic [2:0] cmd);
      send_request(random_request(cmd));
   endtask

   // hold off the sender until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (scoreboard.pending() != 0);
      @(posedge clock);
   endtask

   // commands that a busy sequencer must ignore
   task automatic stray_items(input bit awaiting_reset);
      while ($urandom_range(99) < 8) begin
         case ($urandom_range(6))
            0: send_cmd(CMD_MATCH_ROM);
            1: send_cmd(CMD_SKIP_ROM);
            2: send_cmd(CMD_WRITE_BYTE);
            3: send_cmd(CMD_READ_BYTE);
            4: send_cmd(CMD_RSVD_6);
            5: send_cmd(CMD_RSVD_7);
            default: send_cmd(awaiting_reset ? CMD_SLOT_DONE : CMD_RESET_DONE);
         endcase
      end
   endtask

   // one full operation from its start command to completion
   task automatic run_operation(input logic [2:0] start_cmd, input logic [63:0] id,
                                input logic [7:0] wbyte, input int bit_mode);
      req_type r;
      int      slots;
      r            = random_request(start_cmd);
      r.rom_id     = id;
      r.write_byte = wbyte;
      send_request(r);
      useful_items++;
      if (start_cmd == CMD_MATCH_ROM || start_cmd == CMD_SKIP_ROM) begin
         stray_items(1'b1);
         send_cmd(CMD_RESET_DONE);
         useful_items++;
      end
      slots = int'(ByteBits);
      if (start_cmd == CMD_MATCH_ROM) slots += int'(ByteBits) * int'(IdBytes);
      repeat (slots) begin
         stray_items(1'b0);
         r = random_request(CMD_SLOT_DONE);
         if (bit_mode == BITS_LOW) r.read_bit = 1'b0;
         else if (bit_mode == BITS_HIGH) r.read_bit = 1'b1;
         send_request(r);
         useful_items++;
      end
   endtask

   // idle-time noise, then a random operation
   task automatic run_random_operation();
      int          pick;
      logic [63:0] id;
      logic [7:0]  wbyte;
      while ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0: send_cmd(CMD_RESET_DONE);
            1: send_cmd(CMD_SLOT_DONE);
            2: send_cmd(CMD_RSVD_6);
            default: send_cmd(CMD_RSVD_7);
         endcase
      end
      id    = {$urandom, $urandom};
      wbyte = 8'($urandom_range(255));
      case ($urandom_range(9))
         0: begin id = '0; wbyte = '0; end
         1: begin id = '1; wbyte = '1; end
         default: ;
      endcase
      pick = $urandom_range(99);
      if (pick < 15)      run_operation(CMD_MATCH_ROM, id, wbyte, BITS_RANDOM);
      else if (pick < 35) run_operation(CMD_SKIP_ROM, id, wbyte, BITS_RANDOM);
      else if (pick < 65) run_operation(CMD_WRITE_BYTE, id, wbyte, BITS_RANDOM);
      else                run_operation(CMD_READ_BYTE, id, wbyte, BITS_RANDOM);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver stalls often
      send_idle_pct = 20;
      rsp_idle_pct  = 55;

      // events while idle are ignored
      send_cmd(CMD_RESET_DONE);
      send_cmd(CMD_SLOT_DONE);
      send_cmd(CMD_RSVD_6);
      send_cmd(CMD_RSVD_7);

      // skip rom with busy starts and wrong-phase events in between
      send_cmd(CMD_SKIP_ROM);
      send_cmd(CMD_SLOT_DONE);
      send_cmd(CMD_MATCH_ROM);
      send_cmd(CMD_RESET_DONE);
      send_cmd(CMD_WRITE_BYTE);
      send_cmd(CMD_READ_BYTE);
      send_cmd(CMD_RESET_DONE);
      send_cmd(CMD_RSVD_7);
      repeat (8) send_cmd(CMD_SLOT_DONE);

      // field extremes
      run_operation(CMD_MATCH_ROM, '1, 8'h00, BITS_RANDOM);
      run_operation(CMD_MATCH_ROM, '0, 8'hFF, BITS_RANDOM);
      run_operation(CMD_WRITE_BYTE, '0, 8'hFF, BITS_RANDOM);
      run_operation(CMD_WRITE_BYTE, '1, 8'h00, BITS_RANDOM);
      run_operation(CMD_READ_BYTE, '1, 8'hFF, BITS_HIGH);
      run_operation(CMD_READ_BYTE, '0, 8'h00, BITS_LOW);

      while (useful_items < PHASE1_ITEMS) run_random_operation();
      wait_drained();

      // sender idles often, receiver stalls lightly
      send_idle_pct = 55;
      rsp_idle_pct  = 20;
      while (useful_items < PHASE2_ITEMS) run_random_operation();

      // full rate on both sides
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      while (useful_items < PHASE3_ITEMS) run_random_operation();

      wait_drained();
      repeat (8) @(posedge clock);
      if (scoreboard.pending() != 0) begin
         $error("%0d expected results never arrived", scoreboard.pending());
         scoreboard.failures++;
      end
      if (scoreboard.failures == 0) begin
         $display("tb_onewire_rom_command_sequencer: PASS");
      end else begin
         $display("tb_onewire_rom_command_sequencer: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/owseq_pkg.sv
hdl/owseq_in_stage.sv
hdl/owseq_core.sv
hdl/owseq_out_stage.sv
hdl/onewire_rom_command_sequencer.sv
verif/tb_onewire_rom_command_sequencer.sv
